// ----- hdl/ptd_pkg.sv -----
package ptd_pkg;

   // input coordinates and derived widths
   localparam int COORD_W   = 18;
   localparam int N_FIELDS  = 12;
   localparam int DIFF_W    = COORD_W + 1;
   localparam int PROD_W    = 2 * DIFF_W;
   localparam int DOT_W     = PROD_W + 2;
   localparam int NRM_W     = PROD_W + 1;
   localparam int S_W       = DIFF_W + NRM_W + 2;
   localparam int DEN_W     = 2 * NRM_W + 2;
   localparam int EDGE_W    = 2 * DOT_W;
   localparam int NUM_W     = 2 * S_W;

   // wide multiplier: 64x64 signed, built from 32x32 partial products
   localparam int MUL_W     = 64;
   localparam int MULP_W    = 2 * MUL_W;

   // result
   localparam int DIST_W    = 38;
   localparam int REG_W     = 3;

   // stream widths
   localparam int REQ_DATA_W = N_FIELDS * COORD_W;
   localparam int RSP_DATA_W = ((DIST_W + 7) / 8) * 8;
   localparam int RSP_USER_W = REG_W + 1;

   localparam int QUEUE_DEPTH = 4;

   typedef enum logic [REG_W-1:0] {
      REGION_FACE   = 3'd0,
      REGION_EDGE01 = 3'd1,
      REGION_EDGE12 = 3'd2,
      REGION_EDGE20 = 3'd3,
      REGION_VERT0  = 3'd4,
      REGION_VERT1  = 3'd5,
      REGION_VERT2  = 3'd6
   } region_type;

   // one classified item: up to three quotient lanes
   typedef struct packed {
      logic [NUM_W-1:0]  num0;
      logic [DEN_W-1:0]  den0;
      logic [EDGE_W-1:0] num1;
      logic [DOT_W-1:0]  den1;
      logic [EDGE_W-1:0] num2;
      logic [DOT_W-1:0]  den2;
      region_type        reg0;
      region_type        reg1;
      region_type        reg2;
      logic              degen;
   } q_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// ----- hdl/ptd_mul.sv -----
module ptd_mul (
   input  logic                               clock,
   input  logic                               en,
   input  logic signed [ptd_pkg::MUL_W-1:0]   a,
   input  logic signed [ptd_pkg::MUL_W-1:0]   b,
   output logic signed [ptd_pkg::MULP_W-1:0]  p
);

   localparam int H = ptd_pkg::MUL_W / 2;

   logic [ptd_pkg::MUL_W-1:0]  ma_in, mb_in, ma_ff, mb_ff;
   logic                       sg1_ff, sg2_ff, sg3_ff;
   logic [ptd_pkg::MUL_W-1:0]  pp_in [4];
   logic [ptd_pkg::MUL_W-1:0]  pp_ff [4];
   logic [ptd_pkg::MULP_W-1:0] sum_in, sum_ff;
   logic [ptd_pkg::MULP_W-1:0] p_in, p_ff;

   // sign-magnitude form, partial products, sum, sign restore
   assign ma_in = a[ptd_pkg::MUL_W-1] ? ptd_pkg::MUL_W'(-a) : ptd_pkg::MUL_W'(a);
   assign mb_in = b[ptd_pkg::MUL_W-1] ? ptd_pkg::MUL_W'(-b) : ptd_pkg::MUL_W'(b);

   assign pp_in[0] = ma_ff[H-1:0] * mb_ff[H-1:0];
   assign pp_in[1] = ma_ff[H-1:0] * mb_ff[2*H-1:H];
   assign pp_in[2] = ma_ff[2*H-1:H] * mb_ff[H-1:0];
   assign pp_in[3] = ma_ff[2*H-1:H] * mb_ff[2*H-1:H];

   assign sum_in = {{(2*H){1'b0}}, pp_ff[0]}
                 + {{H{1'b0}}, pp_ff[1], {H{1'b0}}}
                 + {{H{1'b0}}, pp_ff[2], {H{1'b0}}}
                 + {pp_ff[3], {(2*H){1'b0}}};

   assign p_in = sg3_ff ? (~sum_ff + ptd_pkg::MULP_W'(1)) : sum_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         ma_ff  <= ma_in;
         mb_ff  <= mb_in;
         sg1_ff <= a[ptd_pkg::MUL_W-1] ^ b[ptd_pkg::MUL_W-1];
         for (int i = 0; i < 4; i++) begin
            pp_ff[i] <= pp_in[i];
         end
         sg2_ff <= sg1_ff;
         sum_ff <= sum_in;
         sg3_ff <= sg2_ff;
         p_ff   <= p_in;
      end
   end

   assign p = $signed(p_ff);

endmodule

// ----- hdl/ptd_front.sv -----
module ptd_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [ptd_pkg::REQ_DATA_W-1:0]        req_tdata,
   input  ptd_pkg::queue_status_type             q_status,
   output logic                                  push,
   output ptd_pkg::q_entry_type                  entry
);

   localparam int DEPTH  = 12;
   localparam int N_DOT  = 13;
   localparam int N_MUL  = 19;
   localparam int N_VEC  = 6;

   localparam int V_AB = 0, V_AC = 1, V_BC = 2, V_AP = 3, V_BP = 4, V_CP = 5;
   localparam int I_D1 = 0, I_D2 = 1, I_D3 = 2, I_D4 = 3, I_D5 = 4, I_D6 = 5;
   localparam int I_AA = 6, I_BB = 7, I_CC = 8, I_LAB = 9, I_LAC = 10, I_LBC = 11;
   localparam int I_TBC = 12;
   localparam int M_SS = 18;

   // vector = coordinate[VHI] - coordinate[VLO] (base index of x)
   localparam int VHI [N_VEC] = '{3, 6, 6, 9, 9, 9};
   localparam int VLO [N_VEC] = '{0, 0, 3, 0, 3, 6};
   localparam int DL [N_DOT] = '{V_AB, V_AC, V_AB, V_AC, V_AB, V_AC,
                                  V_AP, V_BP, V_CP, V_AB, V_AC, V_BC, V_BC};
   localparam int DR [N_DOT] = '{V_AP, V_AP, V_BP, V_BP, V_CP, V_CP,
                                  V_AP, V_BP, V_CP, V_AB, V_AC, V_BC, V_BP};
   // normal terms: ab[NLK] * ac[NRK]
   localparam int NLK [6] = '{1, 2, 2, 0, 0, 1};
   localparam int NRK [6] = '{2, 1, 0, 2, 1, 0};

   typedef struct packed {
      logic [N_DOT-1:0][ptd_pkg::DOT_W-1:0] dot;
      logic                                 degen;
   } dly_type;

   logic                fe;
   logic [DEPTH:1]      v_ff;

   logic signed [ptd_pkg::COORD_W-1:0] crd [ptd_pkg::N_FIELDS];
   logic signed [ptd_pkg::DIFF_W-1:0]  vec_in [N_VEC][3];
   logic signed [ptd_pkg::DIFF_W-1:0]  vec_ff [N_VEC][3];
   logic signed [ptd_pkg::PROD_W-1:0]  prd_in [N_DOT][3];
   logic signed [ptd_pkg::PROD_W-1:0]  prd_ff [N_DOT][3];
   logic signed [ptd_pkg::PROD_W-1:0]  pn_in [6];
   logic signed [ptd_pkg::PROD_W-1:0]  pn_ff [6];
   logic signed [ptd_pkg::DIFF_W-1:0]  ap2_ff [3];
   logic signed [ptd_pkg::DIFF_W-1:0]  ap3_ff [3];
   logic signed [ptd_pkg::DOT_W-1:0]   dot_in [N_DOT];
   logic signed [ptd_pkg::DOT_W-1:0]   dot_ff [N_DOT];
   logic signed [ptd_pkg::NRM_W-1:0]   nrm_in [3];
   logic signed [ptd_pkg::NRM_W-1:0]   nrm_ff [3];
   logic                               degen3;
   dly_type                            dly_in;
   dly_type                            dly_ff [5];

   logic signed [ptd_pkg::MUL_W-1:0]   ma_op [N_MUL];
   logic signed [ptd_pkg::MUL_W-1:0]   mb_op [N_MUL];
   logic signed [ptd_pkg::MULP_W-1:0]  mp [N_MUL];

   logic signed [ptd_pkg::MULP_W-1:0]  vdiff [3];
   logic signed [ptd_pkg::S_W-1:0]     s8_in, s8_ff;
   logic [ptd_pkg::DEN_W-1:0]          den8_in, den8_ff;
   logic [ptd_pkg::EDGE_W-1:0]         en8_in [3];
   logic [ptd_pkg::EDGE_W-1:0]         en8_ff [3];
   logic [2:0]                         np8_in, np8_ff;

   ptd_pkg::q_entry_type               lane_in;
   logic                               face_in;
   ptd_pkg::q_entry_type               lane_ff [4];
   logic                               face_ff [4];

   // whole front advances together; it stalls only on a full queue
   assign fe         = !v_ff[DEPTH] || !q_status.full;
   assign req_tready = fe;
   assign push       = v_ff[DEPTH] && !q_status.full;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (fe) begin
         v_ff <= {v_ff[DEPTH-1:1], req_tvalid};
      end
   end

   // stage 1: edge and point vectors
   always_comb begin
      for (int i = 0; i < ptd_pkg::N_FIELDS; i++) begin
         crd[i] = $signed(req_tdata[i*ptd_pkg::COORD_W +: ptd_pkg::COORD_W]);
      end
      for (int v = 0; v < N_VEC; v++) begin
         for (int k = 0; k < 3; k++) begin
            vec_in[v][k] = ptd_pkg::DIFF_W'(crd[VHI[v]+k]) - ptd_pkg::DIFF_W'(crd[VLO[v]+k]);
         end
      end
   end

   // stage 2: component products
   always_comb begin
      for (int d = 0; d < N_DOT; d++) begin
         for (int k = 0; k < 3; k++) begin
            prd_in[d][k] = vec_ff[DL[d]][k] * vec_ff[DR[d]][k];
         end
      end
      for (int j = 0; j < 6; j++) begin
         pn_in[j] = vec_ff[V_AB][NLK[j]] * vec_ff[V_AC][NRK[j]];
      end
   end

   // stage 3: dot products and normal
   always_comb begin
      for (int d = 0; d < N_DOT; d++) begin
         dot_in[d] = ptd_pkg::DOT_W'(prd_ff[d][0]) + ptd_pkg::DOT_W'(prd_ff[d][1])
                   + ptd_pkg::DOT_W'(prd_ff[d][2]);
      end
      for (int k = 0; k < 3; k++) begin
         nrm_in[k] = ptd_pkg::NRM_W'(pn_ff[2*k]) - ptd_pkg::NRM_W'(pn_ff[2*k+1]);
      end
   end

   assign degen3 = (dot_ff[I_LAB] == 0) || (dot_ff[I_LAC] == 0) || (dot_ff[I_LBC] == 0)
                || ((nrm_ff[0] == 0) && (nrm_ff[1] == 0) && (nrm_ff[2] == 0));

   always_comb begin
      for (int d = 0; d < N_DOT; d++) begin
         dly_in.dot[d] = dot_ff[d];
      end
      dly_in.degen = degen3;
   end

   // wide products: region tests, edge numerators, face terms, face square
   always_comb begin
      ma_op[0]  = ptd_pkg::MUL_W'(dot_ff[I_D1]);  mb_op[0]  = ptd_pkg::MUL_W'(dot_ff[I_D4]);
      ma_op[1]  = ptd_pkg::MUL_W'(dot_ff[I_D3]);  mb_op[1]  = ptd_pkg::MUL_W'(dot_ff[I_D2]);
      ma_op[2]  = ptd_pkg::MUL_W'(dot_ff[I_D5]);  mb_op[2]  = ptd_pkg::MUL_W'(dot_ff[I_D2]);
      ma_op[3]  = ptd_pkg::MUL_W'(dot_ff[I_D1]);  mb_op[3]  = ptd_pkg::MUL_W'(dot_ff[I_D6]);
      ma_op[4]  = ptd_pkg::MUL_W'(dot_ff[I_D3]);  mb_op[4]  = ptd_pkg::MUL_W'(dot_ff[I_D6]);
      ma_op[5]  = ptd_pkg::MUL_W'(dot_ff[I_D5]);  mb_op[5]  = ptd_pkg::MUL_W'(dot_ff[I_D4]);
      ma_op[6]  = ptd_pkg::MUL_W'(dot_ff[I_AA]);  mb_op[6]  = ptd_pkg::MUL_W'(dot_ff[I_LAB]);
      ma_op[7]  = ptd_pkg::MUL_W'(dot_ff[I_D1]);  mb_op[7]  = ptd_pkg::MUL_W'(dot_ff[I_D1]);
      ma_op[8]  = ptd_pkg::MUL_W'(dot_ff[I_BB]);  mb_op[8]  = ptd_pkg::MUL_W'(dot_ff[I_LBC]);
      ma_op[9]  = ptd_pkg::MUL_W'(dot_ff[I_TBC]); mb_op[9]  = ptd_pkg::MUL_W'(dot_ff[I_TBC]);
      // third lane: segment from P2 when degenerate, edge P0-P2 seen from P0 otherwise
      ma_op[10] = ptd_pkg::MUL_W'(degen3 ? dot_ff[I_CC] : dot_ff[I_AA]);
      mb_op[10] = ptd_pkg::MUL_W'(dot_ff[I_LAC]);
      ma_op[11] = ptd_pkg::MUL_W'(degen3 ? dot_ff[I_D6] : dot_ff[I_D2]);
      mb_op[11] = ptd_pkg::MUL_W'(degen3 ? dot_ff[I_D6] : dot_ff[I_D2]);
      for (int k = 0; k < 3; k++) begin
         ma_op[12+k] = ptd_pkg::MUL_W'(ap3_ff[k]);
         mb_op[12+k] = ptd_pkg::MUL_W'(nrm_ff[k]);
         ma_op[15+k] = ptd_pkg::MUL_W'(nrm_ff[k]);
         mb_op[15+k] = ptd_pkg::MUL_W'(nrm_ff[k]);
      end
      ma_op[M_SS] = ptd_pkg::MUL_W'(s8_ff);
      mb_op[M_SS] = ptd_pkg::MUL_W'(s8_ff);
   end

   for (genvar i = 0; i < N_MUL; i++) begin : g_mul
      ptd_mul u_mul (
         .clock (clock),
         .en    (fe),
         .a     (ma_op[i]),
         .b     (mb_op[i]),
         .p     (mp[i])
      );
   end

   // stage 8 inputs: sums and differences of the wide products
   always_comb begin
      s8_in   = ptd_pkg::S_W'(mp[12] + mp[13] + mp[14]);
      den8_in = ptd_pkg::DEN_W'(mp[15] + mp[16] + mp[17]);
      for (int j = 0; j < 3; j++) begin
         en8_in[j] = ptd_pkg::EDGE_W'(mp[6+2*j] - mp[7+2*j]);
         vdiff[j]  = mp[2*j] - mp[2*j+1];
         np8_in[j] = vdiff[j][ptd_pkg::MULP_W-1] || (vdiff[j] == 0);
      end
   end

   // stage 8: region classification
   always_comb begin
      logic signed [ptd_pkg::DOT_W-1:0] d1, d2, d3, d4, d5, d6, lab, lac, lbc, tbc;
      logic [ptd_pkg::NUM_W-1:0]        aa, bb, cc;
      d1  = $signed(dly_ff[4].dot[I_D1]);
      d2  = $signed(dly_ff[4].dot[I_D2]);
      d3  = $signed(dly_ff[4].dot[I_D3]);
      d4  = $signed(dly_ff[4].dot[I_D4]);
      d5  = $signed(dly_ff[4].dot[I_D5]);
      d6  = $signed(dly_ff[4].dot[I_D6]);
      lab = $signed(dly_ff[4].dot[I_LAB]);
      lac = $signed(dly_ff[4].dot[I_LAC]);
      lbc = $signed(dly_ff[4].dot[I_LBC]);
      tbc = $signed(dly_ff[4].dot[I_TBC]);
      aa  = ptd_pkg::NUM_W'(dly_ff[4].dot[I_AA]);
      bb  = ptd_pkg::NUM_W'(dly_ff[4].dot[I_BB]);
      cc  = ptd_pkg::NUM_W'(dly_ff[4].dot[I_CC]);

      lane_in       = '0;
      lane_in.den1  = ptd_pkg::DOT_W'(1);
      lane_in.den2  = ptd_pkg::DOT_W'(1);
      lane_in.reg0  = ptd_pkg::REGION_VERT0;
      lane_in.reg1  = ptd_pkg::REGION_VERT1;
      lane_in.reg2  = ptd_pkg::REGION_VERT2;
      lane_in.degen = dly_ff[4].degen;
      face_in       = 1'b0;

      if (dly_ff[4].degen) begin
         // segment P0-P1
         if (d1 <= 0) begin
            lane_in.reg0 = ptd_pkg::REGION_VERT0;
            lane_in.num0 = aa;
            lane_in.den0 = ptd_pkg::DEN_W'(1);
         end else if (d1 >= lab) begin
            lane_in.reg0 = ptd_pkg::REGION_VERT1;
            lane_in.num0 = bb;
            lane_in.den0 = ptd_pkg::DEN_W'(1);
         end else begin
            lane_in.reg0 = ptd_pkg::REGION_EDGE01;
            lane_in.num0 = ptd_pkg::NUM_W'(en8_ff[0]);
            lane_in.den0 = ptd_pkg::DEN_W'(lab);
         end
         // segment P1-P2
         if (tbc <= 0) begin
            lane_in.reg1 = ptd_pkg::REGION_VERT1;
            lane_in.num1 = ptd_pkg::EDGE_W'(bb);
         end else if (tbc >= lbc) begin
            lane_in.reg1 = ptd_pkg::REGION_VERT2;
            lane_in.num1 = ptd_pkg::EDGE_W'(cc);
         end else begin
            lane_in.reg1 = ptd_pkg::REGION_EDGE12;
            lane_in.num1 = en8_ff[1];
            lane_in.den1 = lbc;
         end
         // segment from P2 along P0->P2
         if (d6 <= 0) begin
            lane_in.reg2 = ptd_pkg::REGION_VERT2;
            lane_in.num2 = ptd_pkg::EDGE_W'(cc);
         end else if (d6 >= lac) begin
            lane_in.reg2 = ptd_pkg::REGION_VERT0;
            lane_in.num2 = ptd_pkg::EDGE_W'(aa);
         end else begin
            lane_in.reg2 = ptd_pkg::REGION_EDGE20;
            lane_in.num2 = en8_ff[2];
            lane_in.den2 = lac;
         end
      end else begin
         lane_in.den0 = ptd_pkg::DEN_W'(1);
         if (d1 <= 0 && d2 <= 0) begin
            lane_in.reg0 = ptd_pkg::REGION_VERT0;
            lane_in.num0 = aa;
         end else if (d3 >= 0 && d4 <= d3) begin
            lane_in.reg0 = ptd_pkg::REGION_VERT1;
            lane_in.num0 = bb;
         end else if (np8_ff[0] && d1 >= 0 && d3 <= 0) begin
            lane_in.reg0 = ptd_pkg::REGION_EDGE01;
            lane_in.num0 = ptd_pkg::NUM_W'(en8_ff[0]);
            lane_in.den0 = ptd_pkg::DEN_W'(lab);
         end else if (d6 >= 0 && d5 <= d6) begin
            lane_in.reg0 = ptd_pkg::REGION_VERT2;
            lane_in.num0 = cc;
         end else if (np8_ff[1] && d2 >= 0 && d6 <= 0) begin
            lane_in.reg0 = ptd_pkg::REGION_EDGE20;
            lane_in.num0 = ptd_pkg::NUM_W'(en8_ff[2]);
            lane_in.den0 = ptd_pkg::DEN_W'(lac);
         end else if (np8_ff[2] && d4 >= d3 && d5 >= d6) begin
            lane_in.reg0 = ptd_pkg::REGION_EDGE12;
            lane_in.num0 = ptd_pkg::NUM_W'(en8_ff[1]);
            lane_in.den0 = ptd_pkg::DEN_W'(lbc);
         end else begin
            // numerator (ap.n)^2 is taken from the square multiplier when the lane leaves lane_ff
            lane_in.reg0 = ptd_pkg::REGION_FACE;
            lane_in.den0 = den8_ff;
            face_in      = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fe) begin
         vec_ff <= vec_in;
         prd_ff <= prd_in;
         pn_ff  <= pn_in;
         ap2_ff <= vec_ff[V_AP];
         dot_ff <= dot_in;
         nrm_ff <= nrm_in;
         ap3_ff <= ap2_ff;
         dly_ff[0] <= dly_in;
         for (int i = 1; i < 5; i++) begin
            dly_ff[i] <= dly_ff[i-1];
         end
         s8_ff   <= s8_in;
         den8_ff <= den8_in;
         en8_ff  <= en8_in;
         np8_ff  <= np8_in;
         lane_ff[0] <= lane_in;
         face_ff[0] <= face_in;
         for (int i = 1; i < 4; i++) begin
            lane_ff[i] <= lane_ff[i-1];
            face_ff[i] <= face_ff[i-1];
         end
      end
   end

   always_comb begin
      entry = lane_ff[3];
      if (face_ff[3]) begin
         entry.num0 = mp[M_SS][ptd_pkg::NUM_W-1:0];
      end
   end

endmodule

// ----- hdl/ptd_queue.sv -----
module ptd_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  ptd_pkg::q_entry_type       wr_entry,
   input  logic                       pop,
   output ptd_pkg::q_entry_type       rd_entry,
   output ptd_pkg::queue_status_type  status
);

   localparam int PTR_W = $clog2(ptd_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(ptd_pkg::QUEUE_DEPTH + 1);

   ptd_pkg::q_entry_type slot_ff [ptd_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;

   assign status.full  = (cnt_ff == CNT_W'(ptd_pkg::QUEUE_DEPTH));
   assign status.empty = (cnt_ff == '0);
   assign rd_entry     = slot_ff[rd_ptr_ff];

   assign wr_ptr_in = push ? PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
   assign rd_ptr_in = pop  ? PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;

   always_comb begin
      cnt_in = cnt_ff;
      case ({push, pop})
         2'b10:   cnt_in = CNT_W'(cnt_ff + 1'b1);
         2'b01:   cnt_in = CNT_W'(cnt_ff - 1'b1);
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= wr_entry;
      end
   end

endmodule

// ----- hdl/ptd_divider.sv -----
module ptd_divider (
   input  logic                         clock,
   input  logic                         en,
   input  logic [ptd_pkg::NUM_W-1:0]    num,
   input  logic [ptd_pkg::DEN_W-1:0]    den,
   output logic [ptd_pkg::DIST_W-1:0]   quo
);

   localparam int N = ptd_pkg::DIST_W;

   // restoring division, one quotient bit per stage, MSB first
   logic [ptd_pkg::NUM_W-1:0]  rem_ff [N];
   logic [ptd_pkg::DEN_W-1:0]  den_ff [N];
   logic [ptd_pkg::DIST_W-1:0] q_ff   [N];

   for (genvar i = 0; i < N; i++) begin : g_stage
      logic [ptd_pkg::NUM_W-1:0]  src_rem, sh, rem_in;
      logic [ptd_pkg::DEN_W-1:0]  src_den;
      logic [ptd_pkg::DIST_W-1:0] src_q, q_in;
      logic                       ge;

      if (i == 0) begin : g_first
         assign src_rem = num;
         assign src_den = den;
         assign src_q   = '0;
      end else begin : g_next
         assign src_rem = rem_ff[i-1];
         assign src_den = den_ff[i-1];
         assign src_q   = q_ff[i-1];
      end

      assign sh     = ptd_pkg::NUM_W'(src_den) << (N - 1 - i);
      assign ge     = (src_rem >= sh);
      assign rem_in = ge ? (src_rem - sh) : src_rem;
      assign q_in   = src_q | (ptd_pkg::DIST_W'(ge) << (N - 1 - i));

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i] <= rem_in;
            den_ff[i] <= src_den;
            q_ff[i]   <= q_in;
         end
      end
   end

   assign quo = q_ff[N-1];

endmodule

// ----- hdl/ptd_back.sv -----
module ptd_back (
   input  logic                               clock,
   input  logic                               reset,
   input  ptd_pkg::queue_status_type          q_status,
   input  ptd_pkg::q_entry_type               entry,
   output logic                               pop,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [ptd_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic [ptd_pkg::RSP_USER_W-1:0]     rsp_tuser
);

   localparam int N = ptd_pkg::DIST_W;

   typedef struct packed {
      ptd_pkg::region_type reg0;
      ptd_pkg::region_type reg1;
      ptd_pkg::region_type reg2;
      logic                degen;
   } tag_type;

   logic                        be;
   logic [N-1:0]                vb_ff;
   logic                        ob_ff;
   tag_type                     tag_in;
   tag_type                     tag_ff [N];
   logic [ptd_pkg::DIST_W-1:0]  quo [3];
   logic [ptd_pkg::DIST_W-1:0]  dist_in, dist_ff;
   ptd_pkg::region_type         region_in, region_ff;
   logic                        degen_ff;

   assign be  = !ob_ff || rsp_tready;
   assign pop = be && !q_status.empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         vb_ff <= '0;
         ob_ff <= 1'b0;
      end else if (be) begin
         vb_ff <= {vb_ff[N-2:0], pop};
         ob_ff <= vb_ff[N-1];
      end
   end

   ptd_divider u_div0 (
      .clock (clock),
      .en    (be),
      .num   (entry.num0),
      .den   (entry.den0),
      .quo   (quo[0])
   );

   ptd_divider u_div1 (
      .clock (clock),
      .en    (be),
      .num   (ptd_pkg::NUM_W'(entry.num1)),
      .den   (ptd_pkg::DEN_W'(entry.den1)),
      .quo   (quo[1])
   );

   ptd_divider u_div2 (
      .clock (clock),
      .en    (be),
      .num   (ptd_pkg::NUM_W'(entry.num2)),
      .den   (ptd_pkg::DEN_W'(entry.den2)),
      .quo   (quo[2])
   );

   assign tag_in = '{reg0: entry.reg0, reg1: entry.reg1, reg2: entry.reg2, degen: entry.degen};

   // degenerate: smallest of the three segments, earlier lane wins ties
   always_comb begin
      dist_in   = quo[0];
      region_in = tag_ff[N-1].reg0;
      if (tag_ff[N-1].degen) begin
         if (quo[1] < dist_in) begin
            dist_in   = quo[1];
            region_in = tag_ff[N-1].reg1;
         end
         if (quo[2] < dist_in) begin
            dist_in   = quo[2];
            region_in = tag_ff[N-1].reg2;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (be) begin
         tag_ff[0] <= tag_in;
         for (int i = 1; i < N; i++) begin
            tag_ff[i] <= tag_ff[i-1];
         end
         dist_ff   <= dist_in;
         region_ff <= region_in;
         degen_ff  <= tag_ff[N-1].degen;
      end
   end

   assign rsp_tvalid = ob_ff;
   assign rsp_tdata  = ptd_pkg::RSP_DATA_W'(dist_ff);
   assign rsp_tuser  = {degen_ff, region_ff};

endmodule

// ----- hdl/point_triangle_distance_sq_top.sv -----
// Throughput: one transaction per cycle while rsp_tready does not hold the back and fill the queue.
// Front: 12-stage arithmetic pipeline (64x64 multipliers, four stages each).
// Back: three 38-stage restoring dividers, one quotient bit per stage.
// Reset: synchronous, active high; clears valid bits and queue pointers and count only.
module point_triangle_distance_sq_top (
   input  logic                               clock,
   input  logic                               reset,
   // req_tdata, low bit up: p0_x p0_y p0_z p1_x p1_y p1_z p2_x p2_y p2_z
   //                        query_x query_y query_z (18 bits each, signed)
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [ptd_pkg::REQ_DATA_W-1:0]     req_tdata,
   // rsp_tdata, low bit up: distance_sq (38 bits), 2 zero bits
   // rsp_tuser, low bit up: closest_region (3 bits), degenerate (1 bit)
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [ptd_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic [ptd_pkg::RSP_USER_W-1:0]     rsp_tuser
);

   ptd_pkg::queue_status_type q_status;
   ptd_pkg::q_entry_type      wr_entry;
   ptd_pkg::q_entry_type      rd_entry;
   logic                      push;
   logic                      pop;

   // front: vectors, dot products, normal, wide products, region select
   ptd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_status   (q_status),
      .push       (push),
      .entry      (wr_entry)
   );

   // short queue decouples the stall domains
   ptd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .wr_entry (wr_entry),
      .pop      (pop),
      .rd_entry (rd_entry),
      .status   (q_status)
   );

   // back: quotient lanes, minimum over segments, output register
   ptd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_status   (q_status),
      .entry      (rd_entry),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // front only stalls when the queue is full
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> q_status.full)
      else $error("front stalled with room in queue");

   // region code 7 is never produced
   a_region_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser[2:0] != 3'd7))
      else $error("invalid region code");

   // a degenerate triangle never reports the face
   a_degen_face: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[3]) |-> (rsp_tuser[2:0] != ptd_pkg::REGION_FACE))
      else $error("face reported for degenerate triangle");

endmodule
